// ===== rtl/stp_pkg.sv =====
// Shared constants, register codes and index tables for the stress tensor product unit.
package stp_pkg;

   // Six independent tensor entries in, six product entries out.
   localparam int unsigned NUM_TERMS       = 6;
   localparam int unsigned NUM_DIMS        = 3;
   localparam int unsigned CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LEFT_ROW0  = 3'd0,
      CSR_LEFT_ROW1  = 3'd1,
      CSR_LEFT_ROW2  = 3'd2,
      CSR_RIGHT_ROW0 = 3'd3,
      CSR_RIGHT_ROW1 = 3'd4,
      CSR_RIGHT_ROW2 = 3'd5
   } csr_index_type;

   // Matrix position of each beat slot: xx, yy, zz, zx, xy, yz on the input side,
   // and (0,0), (1,1), (2,2), (2,0), (0,1), (1,2) on the result side.
   localparam int unsigned ROW_OF [NUM_TERMS] = '{0, 1, 2, 2, 0, 1};
   localparam int unsigned COL_OF [NUM_TERMS] = '{0, 1, 2, 0, 1, 2};

endpackage

// ===== rtl/stp_if.sv =====
// Channel interfaces: stress input, product result and register write.
interface stp_stress_if #(parameter int unsigned STRESS_WIDTH = 32);
   logic                           valid;
   logic                           ready;
   logic signed [STRESS_WIDTH-1:0] s_xx;
   logic signed [STRESS_WIDTH-1:0] s_yy;
   logic signed [STRESS_WIDTH-1:0] s_zz;
   logic signed [STRESS_WIDTH-1:0] s_zx;
   logic signed [STRESS_WIDTH-1:0] s_xy;
   logic signed [STRESS_WIDTH-1:0] s_yz;

   modport source (output valid, s_xx, s_yy, s_zz, s_zx, s_xy, s_yz, input ready);
   modport sink (input valid, s_xx, s_yy, s_zz, s_zx, s_xy, s_yz, output ready);
endinterface

interface stp_result_if #(parameter int unsigned STRESS_WIDTH = 32);
   logic                           valid;
   logic                           ready;
   logic signed [STRESS_WIDTH-1:0] r_xx;
   logic signed [STRESS_WIDTH-1:0] r_yy;
   logic signed [STRESS_WIDTH-1:0] r_zz;
   logic signed [STRESS_WIDTH-1:0] r_zx;
   logic signed [STRESS_WIDTH-1:0] r_xy;
   logic signed [STRESS_WIDTH-1:0] r_yz;

   modport source (output valid, r_xx, r_yy, r_zz, r_zx, r_xy, r_yz, input ready);
   modport sink (input valid, r_xx, r_yy, r_zz, r_zx, r_xy, r_yz, output ready);
endinterface

interface stp_csr_if #(parameter int unsigned DATA_WIDTH = 48);
   logic                                  valid;
   logic                                  ready;
   logic [stp_pkg::CSR_INDEX_WIDTH-1:0]   index;
   logic [DATA_WIDTH-1:0]                 data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/stp_coef_table.sv =====
// Coefficient registers and the combined left-right coefficient for each tensor term.
module stp_coef_table #(
   parameter int unsigned COEF_WIDTH = 16,
   localparam int unsigned KW = 2 * COEF_WIDTH + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   stp_csr_if.sink              csr_bus,
   output logic signed [KW-1:0] coef_ff [stp_pkg::NUM_TERMS][stp_pkg::NUM_TERMS]
);

   localparam int unsigned RW = 3 * COEF_WIDTH;
   localparam int unsigned PW = 2 * COEF_WIDTH;
   localparam logic [RW-1:0] ONE = RW'(1) << (COEF_WIDTH - 2);

   logic [RW-1:0]         left_ff  [stp_pkg::NUM_DIMS];
   logic [RW-1:0]         right_ff [stp_pkg::NUM_DIMS];
   logic [RW-1:0]         left_in  [stp_pkg::NUM_DIMS];
   logic [RW-1:0]         right_in [stp_pkg::NUM_DIMS];
   logic signed [KW-1:0]  coef_in  [stp_pkg::NUM_TERMS][stp_pkg::NUM_TERMS];
   logic                  csr_write;

   function automatic logic signed [COEF_WIDTH-1:0] coef_at(input logic [RW-1:0] row,
                                                            input int unsigned col);
      return row[col*COEF_WIDTH +: COEF_WIDTH];
   endfunction

   assign csr_bus.ready = !reset;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   always_comb begin
      left_in  = left_ff;
      right_in = right_ff;
      if (csr_write) begin
         unique case (stp_pkg::csr_index_type'(csr_bus.index))
            stp_pkg::CSR_LEFT_ROW0:  left_in[0]  = csr_bus.data;
            stp_pkg::CSR_LEFT_ROW1:  left_in[1]  = csr_bus.data;
            stp_pkg::CSR_LEFT_ROW2:  left_in[2]  = csr_bus.data;
            stp_pkg::CSR_RIGHT_ROW0: right_in[0] = csr_bus.data;
            stp_pkg::CSR_RIGHT_ROW1: right_in[1] = csr_bus.data;
            stp_pkg::CSR_RIGHT_ROW2: right_in[2] = csr_bus.data;
            default: ;  // drop writes past the last register
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < stp_pkg::NUM_DIMS; r++) begin
            left_ff[r]  <= ONE << (r * COEF_WIDTH);
            right_ff[r] <= ONE << (r * COEF_WIDTH);
         end
      end else begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   // S is symmetric, so the (a,b) and (b,a) terms share one stress value and
   // their coefficients L(i,a)R(b,j) + L(i,b)R(a,j) fold into one.
   always_comb begin
      logic signed [PW-1:0] direct;
      logic signed [PW-1:0] swapped;
      int unsigned          i, j, a, b;
      for (int k = 0; k < stp_pkg::NUM_TERMS; k++) begin
         for (int p = 0; p < stp_pkg::NUM_TERMS; p++) begin
            i = stp_pkg::ROW_OF[k];
            j = stp_pkg::COL_OF[k];
            a = stp_pkg::ROW_OF[p];
            b = stp_pkg::COL_OF[p];
            direct  = PW'(coef_at(left_ff[i], a)) * PW'(coef_at(right_ff[b], j));
            swapped = PW'(coef_at(left_ff[i], b)) * PW'(coef_at(right_ff[a], j));
            coef_in[k][p] = KW'(direct) + ((a != b) ? KW'(swapped) : KW'(0));
         end
      end
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
   end

endmodule

// ===== rtl/stp_term_mult.sv =====
// Input register and the stage of 36 stress-by-coefficient products.
module stp_term_mult #(
   parameter int unsigned STRESS_WIDTH = 32,
   parameter int unsigned COEF_WIDTH   = 16,
   localparam int unsigned KW = 2 * COEF_WIDTH + 1,
   localparam int unsigned PW = KW + STRESS_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   stp_stress_if.sink           req_bus,
   input  logic signed [KW-1:0] coef [stp_pkg::NUM_TERMS][stp_pkg::NUM_TERMS],
   output logic                 prod_valid,
   input  logic                 prod_ready,
   output logic signed [PW-1:0] prod_ff [stp_pkg::NUM_TERMS][stp_pkg::NUM_TERMS]
);

   logic                           stress_valid_ff;
   logic signed [STRESS_WIDTH-1:0] stress_ff [stp_pkg::NUM_TERMS];
   logic signed [STRESS_WIDTH-1:0] stress_in [stp_pkg::NUM_TERMS];
   logic                           prod_valid_ff;
   logic signed [PW-1:0]           prod_in [stp_pkg::NUM_TERMS][stp_pkg::NUM_TERMS];
   logic                           stress_ready;
   logic                           mult_ready;

   assign mult_ready    = !prod_valid_ff || prod_ready;
   assign stress_ready  = !stress_valid_ff || mult_ready;
   assign req_bus.ready = stress_ready && !reset;
   assign prod_valid    = prod_valid_ff;

   always_comb begin
      stress_in[0] = req_bus.s_xx;
      stress_in[1] = req_bus.s_yy;
      stress_in[2] = req_bus.s_zz;
      stress_in[3] = req_bus.s_zx;
      stress_in[4] = req_bus.s_xy;
      stress_in[5] = req_bus.s_yz;
   end

   always_comb begin
      for (int k = 0; k < stp_pkg::NUM_TERMS; k++) begin
         for (int p = 0; p < stp_pkg::NUM_TERMS; p++) begin
            prod_in[k][p] = PW'(coef[k][p]) * PW'(stress_ff[p]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stress_valid_ff <= 1'b0;
         prod_valid_ff   <= 1'b0;
      end else begin
         if (stress_ready) begin
            stress_valid_ff <= req_bus.valid;
         end
         if (mult_ready) begin
            prod_valid_ff <= stress_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         stress_ff <= stress_in;
      end
      if (mult_ready && stress_valid_ff) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// ===== rtl/stp_sum_round.sv =====
// Two adder stages, then truncation toward zero and saturation into the result register.
module stp_sum_round #(
   parameter int unsigned STRESS_WIDTH = 32,
   parameter int unsigned COEF_WIDTH   = 16,
   localparam int unsigned KW = 2 * COEF_WIDTH + 1,
   localparam int unsigned PW = KW + STRESS_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 prod_valid,
   output logic                 prod_ready,
   input  logic signed [PW-1:0] prod [stp_pkg::NUM_TERMS][stp_pkg::NUM_TERMS],
   stp_result_if.source         rsp_bus
);

   localparam int unsigned HW     = PW + 1;
   localparam int unsigned AW     = PW + 3;
   localparam int unsigned SH     = 2 * (COEF_WIDTH - 2);
   localparam int unsigned NHALF  = stp_pkg::NUM_TERMS / 2;
   localparam logic signed [AW-1:0] BIAS   = {{(AW - SH){1'b0}}, {SH{1'b1}}};
   localparam logic signed [AW-1:0] SAT_HI = {{(AW - STRESS_WIDTH + 1){1'b0}},
                                              {(STRESS_WIDTH - 1){1'b1}}};
   localparam logic signed [AW-1:0] SAT_LO = {{(AW - STRESS_WIDTH + 1){1'b1}},
                                              {(STRESS_WIDTH - 1){1'b0}}};

   logic                           half_valid_ff;
   logic signed [HW-1:0]           half_ff [stp_pkg::NUM_TERMS][NHALF];
   logic signed [HW-1:0]           half_in [stp_pkg::NUM_TERMS][NHALF];
   logic                           acc_valid_ff;
   logic signed [AW-1:0]           acc_ff [stp_pkg::NUM_TERMS];
   logic signed [AW-1:0]           acc_in [stp_pkg::NUM_TERMS];
   logic                           res_valid_ff;
   logic signed [STRESS_WIDTH-1:0] res_ff [stp_pkg::NUM_TERMS];
   logic signed [STRESS_WIDTH-1:0] res_in [stp_pkg::NUM_TERMS];
   logic                           half_ready;
   logic                           acc_ready;
   logic                           res_ready;

   assign res_ready  = !res_valid_ff || rsp_bus.ready;
   assign acc_ready  = !acc_valid_ff || res_ready;
   assign half_ready = !half_valid_ff || acc_ready;
   assign prod_ready = half_ready;

   always_comb begin
      for (int k = 0; k < stp_pkg::NUM_TERMS; k++) begin
         for (int m = 0; m < NHALF; m++) begin
            half_in[k][m] = HW'(prod[k][2*m]) + HW'(prod[k][2*m+1]);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < stp_pkg::NUM_TERMS; k++) begin
         acc_in[k] = AW'(half_ff[k][0]) + AW'(half_ff[k][1]) + AW'(half_ff[k][2]);
      end
   end

   // Bias negative sums so the arithmetic shift rounds toward zero.
   always_comb begin
      logic signed [AW-1:0] biased;
      logic signed [AW-1:0] quot;
      for (int k = 0; k < stp_pkg::NUM_TERMS; k++) begin
         biased = acc_ff[k] + (acc_ff[k][AW-1] ? BIAS : AW'(0));
         quot   = biased >>> SH;
         if (quot > SAT_HI) begin
            res_in[k] = SAT_HI[STRESS_WIDTH-1:0];
         end else if (quot < SAT_LO) begin
            res_in[k] = SAT_LO[STRESS_WIDTH-1:0];
         end else begin
            res_in[k] = quot[STRESS_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_valid_ff <= 1'b0;
         acc_valid_ff  <= 1'b0;
         res_valid_ff  <= 1'b0;
      end else begin
         if (half_ready) begin
            half_valid_ff <= prod_valid;
         end
         if (acc_ready) begin
            acc_valid_ff <= half_valid_ff;
         end
         if (res_ready) begin
            res_valid_ff <= acc_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (half_ready && prod_valid) begin
         half_ff <= half_in;
      end
      if (acc_ready && half_valid_ff) begin
         acc_ff <= acc_in;
      end
      if (res_ready && acc_valid_ff) begin
         res_ff <= res_in;
      end
   end

   assign rsp_bus.valid = res_valid_ff;
   assign rsp_bus.r_xx  = res_ff[0];
   assign rsp_bus.r_yy  = res_ff[1];
   assign rsp_bus.r_zz  = res_ff[2];
   assign rsp_bus.r_zx  = res_ff[3];
   assign rsp_bus.r_xy  = res_ff[4];
   assign rsp_bus.r_yz  = res_ff[5];

   a_beat_enters_sum: assert property (@(posedge clock) disable iff (reset)
      prod_valid && prod_ready |=> half_valid_ff)
      else $error("accepted product beat did not reach the first adder stage");

   a_half_holds: assert property (@(posedge clock) disable iff (reset)
      half_valid_ff && !acc_ready |=> half_valid_ff && $stable(half_ff[0][0]))
      else $error("stalled first adder stage lost its beat");

   a_acc_holds: assert property (@(posedge clock) disable iff (reset)
      acc_valid_ff && !res_ready |=> acc_valid_ff && $stable(acc_ff[0]))
      else $error("stalled accumulator stage lost its beat");

   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !half_valid_ff && !acc_valid_ff && !res_valid_ff |-> prod_ready)
      else $error("empty adder pipeline refused a beat");

endmodule

// ===== rtl/stress_tensor_triple_product_unit.sv =====
// Top level: L * S * R for a symmetric stress tensor, one beat per cycle unless the result channel stalls.
//
//   channel   modport   beat contents
//   req_bus   sink      s_xx s_yy s_zz s_zx s_xy s_yz (signed stress)
//   rsp_bus   source    r_xx r_yy r_zz r_zx r_xy r_yz (P(0,0) (1,1) (2,2) (2,0) (0,1) (1,2))
//   csr_bus   sink      index 0..2 left rows, 3..5 right rows; other indexes dropped
//
// One beat per cycle unless the result channel stalls; a result passes the input register
// (loaded at the accept edge), then the product, pair sum, accumulate and round/saturate
// registers before it is presented.
// Reset clears all stage valids and loads identity matrices; ready is low during reset.
// Each stage holds its beat while the next stage is full and stalled, so bubbles close up under stall.
// A register write is picked up by a beat accepted in the cycle after the write.
module stress_tensor_triple_product_unit #(
   parameter int unsigned STRESS_WIDTH = 32,
   parameter int unsigned COEF_WIDTH   = 16
) (
   input  logic         clock,
   input  logic         reset,
   stp_stress_if.sink   req_bus,
   stp_result_if.source rsp_bus,
   stp_csr_if.sink      csr_bus
);

   localparam int unsigned KW = 2 * COEF_WIDTH + 1;
   localparam int unsigned PW = KW + STRESS_WIDTH;

   logic signed [KW-1:0] coef [stp_pkg::NUM_TERMS][stp_pkg::NUM_TERMS];
   logic signed [PW-1:0] prod [stp_pkg::NUM_TERMS][stp_pkg::NUM_TERMS];
   logic                 prod_valid;
   logic                 prod_ready;

   stp_coef_table #(
      .COEF_WIDTH (COEF_WIDTH)
   ) u_coef_table (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .coef_ff (coef)
   );

   stp_term_mult #(
      .STRESS_WIDTH (STRESS_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
   ) u_term_mult (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .coef       (coef),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod_ff    (prod)
   );

   stp_sum_round #(
      .STRESS_WIDTH (STRESS_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
   ) u_sum_round (
      .clock      (clock),
      .reset      (reset),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod       (prod),
      .rsp_bus    (rsp_bus)
   );

endmodule
